// ===== hdl/mrr_pkg.sv =====
// ----------------------------------------------------------------------------
// mrr_pkg - shared types and constants for the motor duty ramp
// Field widths, register codes, sequencer states and the per-motor record.
// ----------------------------------------------------------------------------
package mrr_pkg;

  localparam int DUTY_W  = 16;
  localparam int PER_W   = 8;
  localparam int CFG_W   = 16;
  localparam int MIDX_W  = 2;   // width of motor_index / out_motor fields
  localparam int CIDX_W  = 2;   // width of the register index

  localparam logic [DUTY_W-1:0] RESET_RAMP_STEP   = 16'd420;
  localparam logic [PER_W-1:0]  RESET_RAMP_PERIOD = 8'd50;
  localparam logic [DUTY_W-1:0] RESET_PWM_TOP     = 16'hFFFF;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_SET  = 1'b1;

  typedef enum logic [CIDX_W-1:0] {
    CFG_RAMP_STEP   = 2'd0,
    CFG_RAMP_PERIOD = 2'd1,
    CFG_PWM_TOP     = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SET,
    ST_SWEEP,
    ST_FLUSH
  } seq_state_e;

  // one memory word per motor
  typedef struct packed {
    logic [DUTY_W-1:0] duty_now;
    logic [DUTY_W-1:0] duty_goal;
    logic              dir_now;
    logic              dir_tgt;
    logic [PER_W-1:0]  step_timer;
    logic              armed;
  } motor_rec_t;

  typedef struct packed {
    logic [MIDX_W-1:0] motor;
    logic [DUTY_W-1:0] duty;
    logic              dir;
    logic              settled;
  } result_t;

endpackage

// ===== hdl/mrr_if.sv =====
// ----------------------------------------------------------------------------
// mrr_if - request and result channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface mrr_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [mrr_pkg::MIDX_W-1:0] motor_index;
  logic [mrr_pkg::DUTY_W-1:0] goal_duty;
  logic                       goal_direction;

  modport source (output valid, req_type, motor_index, goal_duty, goal_direction,
                  input ready);
  modport sink   (input valid, req_type, motor_index, goal_duty, goal_direction,
                  output ready);
endinterface

interface mrr_res_if;
  logic                       valid;
  logic                       ready;
  logic [mrr_pkg::MIDX_W-1:0] out_motor;
  logic [mrr_pkg::DUTY_W-1:0] duty_value;
  logic                       drive_direction;
  logic                       settled;
  logic                       last_of_tick;

  modport source (output valid, out_motor, duty_value, drive_direction, settled,
                  last_of_tick, input ready);
  modport sink   (input valid, out_motor, duty_value, drive_direction, settled,
                  last_of_tick, output ready);
endinterface

// ===== hdl/mrr_state_ram.sv =====
// ----------------------------------------------------------------------------
// mrr_state_ram - per-motor state memory
// One write and one read port, registered read data; per-entry valid bits
// make unwritten entries read as all zero.
// ----------------------------------------------------------------------------
module mrr_state_ram #(
  parameter int DEPTH = 4,
  parameter int AW    = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [AW-1:0]       rd_addr_i,
  output mrr_pkg::motor_rec_t rd_data_o,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  mrr_pkg::motor_rec_t wr_data_i
);
  import mrr_pkg::*;

  motor_rec_t             mem [DEPTH];
  logic [DEPTH-1:0]       vld_q;
  motor_rec_t             rd_data_q;
  logic                   rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== hdl/mrr_step_calc.sv =====
// ----------------------------------------------------------------------------
// mrr_step_calc - timer count-down and one ramp step for one motor
// Combinational update of a motor record read from the state memory.
// ----------------------------------------------------------------------------
module mrr_step_calc (
  input  mrr_pkg::motor_rec_t           cur_i,
  input  logic [mrr_pkg::DUTY_W-1:0]    ramp_step_i,
  input  logic [mrr_pkg::PER_W-1:0]     ramp_period_i,
  output mrr_pkg::motor_rec_t           nxt_o,
  output logic                          fire_o,
  output logic                          settled_o
);
  import mrr_pkg::*;

  logic [DUTY_W-1:0] d, g, s;
  logic [DUTY_W-1:0] up_gap, dn_gap, left;
  logic [DUTY_W-1:0] duty_n;
  logic              dir_n;
  logic              done;

  assign d      = cur_i.duty_now;
  assign g      = cur_i.duty_goal;
  assign s      = ramp_step_i;
  assign up_gap = g - d;
  assign dn_gap = d - g;
  assign left   = s - d;

  // ramp step proper
  always_comb begin
    duty_n = d;
    dir_n  = cur_i.dir_now;
    if (cur_i.dir_now == cur_i.dir_tgt) begin
      if (g > d) begin
        duty_n = (up_gap >= s) ? d + s : g;
      end else if (g < d) begin
        duty_n = (dn_gap >= s) ? d - s : g;
      end
    end else if (d > s) begin
      duty_n = d - s;
    end else begin
      // crossing zero: flip, then spend the leftover upward
      dir_n  = cur_i.dir_tgt;
      duty_n = (left >= g) ? g : left;
    end
  end

  assign done = (duty_n == g) && (dir_n == cur_i.dir_tgt);

  always_comb begin
    nxt_o     = cur_i;
    fire_o    = 1'b0;
    settled_o = 1'b0;
    if (cur_i.armed) begin
      if (cur_i.step_timer > PER_W'(1)) begin
        nxt_o.step_timer = cur_i.step_timer - PER_W'(1);
      end else begin
        fire_o         = 1'b1;
        settled_o      = done;
        nxt_o.duty_now = duty_n;
        nxt_o.dir_now  = dir_n;
        if (done) begin
          nxt_o.armed      = 1'b0;
          nxt_o.step_timer = '0;
        end else begin
          nxt_o.step_timer = ramp_period_i;
        end
      end
    end
  end

endmodule

// ===== hdl/mrr_out_stage.sv =====
// ----------------------------------------------------------------------------
// mrr_out_stage - result holding and output register
// Keeps one result back so the final result of a tick can be marked.
// ----------------------------------------------------------------------------
module mrr_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mrr_pkg::result_t push_data_i,
  input  logic             flush_i,
  output logic             push_ok_o,
  output logic             pend_vld_o,
  mrr_res_if.source        res_o
);
  import mrr_pkg::*;

  result_t pend_q, pend_d;
  logic    pend_vld_q, pend_vld_d;
  result_t out_q, out_d;
  logic    out_last_q, out_last_d;
  logic    out_vld_q, out_vld_d;
  logic    out_free;

  assign out_free  = !out_vld_q || res_o.ready;
  assign push_ok_o = !pend_vld_q || out_free;

  always_comb begin
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    out_d      = out_q;
    out_last_d = out_last_q;
    out_vld_d  = out_vld_q && !res_o.ready;
    if (push_i) begin
      if (pend_vld_q) begin
        out_d      = pend_q;
        out_last_d = 1'b0;
        out_vld_d  = 1'b1;
      end
      pend_d     = push_data_i;
      pend_vld_d = 1'b1;
    end else if (flush_i && pend_vld_q && out_free) begin
      out_d      = pend_q;
      out_last_d = 1'b1;
      out_vld_d  = 1'b1;
      pend_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign pend_vld_o            = pend_vld_q;
  assign res_o.valid           = out_vld_q;
  assign res_o.out_motor       = out_q.motor;
  assign res_o.duty_value      = out_q.duty;
  assign res_o.drive_direction = out_q.dir;
  assign res_o.settled         = out_q.settled;
  assign res_o.last_of_tick    = out_last_q;

endmodule

// ===== hdl/motor_pwm_ramp_with_reversal.sv =====
// ----------------------------------------------------------------------------
// motor_pwm_ramp_with_reversal - per-motor duty slew limiter with reversal
// Sequencer around a state memory: set-goal writes and tick sweeps.
// ----------------------------------------------------------------------------
// Set goal: memory read on the transfer, then merged write-back; no result.
// Tick: transfer, then one motor read per cycle unless the sweep stalls, each
//   written back once its read data is back, then one flush state.
// A result is held until the next one or the flush; two waiting results stall
//   the sweep.
// Reset: valid bits clear at once so every motor reads as zero; no clearing pass.
module motor_pwm_ramp_with_reversal #(
  parameter int MOTOR_COUNT = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mrr_pkg::CIDX_W-1:0]  cfg_idx_i,
  input  logic [mrr_pkg::CFG_W-1:0]   cfg_data_i,
  mrr_req_if.sink                     req_i,
  mrr_res_if.source                   res_o
);
  import mrr_pkg::*;

  localparam int AW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam logic [AW-1:0] LAST_MOTOR = AW'(MOTOR_COUNT - 1);

  // configuration registers
  logic [DUTY_W-1:0] ramp_step_q;
  logic [PER_W-1:0]  ramp_period_q;
  logic [DUTY_W-1:0] pwm_top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_step_q   <= RESET_RAMP_STEP;
      ramp_period_q <= RESET_RAMP_PERIOD;
      pwm_top_q     <= RESET_PWM_TOP;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RAMP_STEP:   ramp_step_q   <= cfg_data_i;
        CFG_RAMP_PERIOD: ramp_period_q <= cfg_data_i[PER_W-1:0];
        CFG_PWM_TOP:     pwm_top_q     <= cfg_data_i;
        default: ;       // unmapped index: ignored
      endcase
    end
  end

  // sequencer state
  seq_state_e        state_q, state_d;
  logic [AW-1:0]     cnt_q, cnt_d;        // next motor to read in a sweep
  logic              done_q, done_d;      // every motor read issued
  logic              s1_vld_q, s1_vld_d;  // read data is back this cycle
  logic [AW-1:0]     s1_idx_q, s1_idx_d;

  // latched set-goal item, goal already clamped
  logic [AW-1:0]     item_idx_q, item_idx_d;
  logic [DUTY_W-1:0] goal_q, goal_d;
  logic              gdir_q, gdir_d;

  // memory and datapath
  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  motor_rec_t        rd_data, wr_data, step_nxt;
  logic              fire, settled;
  logic              push, flush, push_ok, pend_vld;
  logic              s1_go, advance;
  logic              in_range;
  result_t           push_data;

  assign in_range = 32'(req_i.motor_index) < MOTOR_COUNT;

  mrr_state_ram #(
    .DEPTH (MOTOR_COUNT),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  mrr_step_calc u_step (
    .cur_i         (rd_data),
    .ramp_step_i   (ramp_step_q),
    .ramp_period_i (ramp_period_q),
    .nxt_o         (step_nxt),
    .fire_o        (fire),
    .settled_o     (settled)
  );

  assign push_data.motor   = MIDX_W'(s1_idx_q);
  assign push_data.duty    = step_nxt.duty_now;
  assign push_data.dir     = step_nxt.dir_now;
  assign push_data.settled = settled;

  mrr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .flush_i     (flush),
    .push_ok_o   (push_ok),
    .pend_vld_o  (pend_vld),
    .res_o       (res_o)
  );

  // sweep stage advances unless a result has nowhere to go
  assign s1_go   = !s1_vld_q || !fire || push_ok;
  assign advance = (state_q == ST_SWEEP) && s1_go;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    done_d      = done_q;
    s1_vld_d    = s1_vld_q;
    s1_idx_d    = s1_idx_q;
    item_idx_d  = item_idx_q;
    goal_d      = goal_q;
    gdir_d      = gdir_q;
    req_i.ready = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = cnt_q;
    wr_en       = 1'b0;
    wr_addr     = s1_idx_q;
    wr_data     = step_nxt;
    push        = 1'b0;
    flush       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        // ready is high here, so valid alone marks the transfer
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          item_idx_d = AW'(req_i.motor_index);
          goal_d     = (req_i.goal_duty > pwm_top_q) ? pwm_top_q : req_i.goal_duty;
          gdir_d     = req_i.goal_direction;
          if (req_i.req_type == REQ_SET) begin
            if (in_range) begin
              rd_en   = 1'b1;
              rd_addr = AW'(req_i.motor_index);
              state_d = ST_SET;
            end
          end else begin
            cnt_d    = '0;
            done_d   = 1'b0;
            s1_vld_d = 1'b0;
            state_d  = ST_SWEEP;
          end
        end
      end

      ST_SET: begin
        // keep the running duty and direction, replace goal, target direction and timer, and arm
        wr_en              = 1'b1;
        wr_addr            = item_idx_q;
        wr_data            = rd_data;
        wr_data.duty_goal  = goal_q;
        wr_data.dir_tgt    = gdir_q;
        wr_data.step_timer = ramp_period_q;
        wr_data.armed      = 1'b1;
        state_d            = ST_IDLE;
      end

      ST_SWEEP: begin
        if (s1_vld_q && s1_go) begin
          wr_en = 1'b1;
          push  = fire;
        end
        if (advance) begin
          if (!done_q) begin
            rd_en    = 1'b1;
            s1_vld_d = 1'b1;
            s1_idx_d = cnt_q;
            if (cnt_q == LAST_MOTOR) begin
              done_d = 1'b1;
            end else begin
              cnt_d = cnt_q + AW'(1);
            end
          end else begin
            s1_vld_d = 1'b0;
            state_d  = ST_FLUSH;
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_vld) begin
          state_d = ST_IDLE;
        end else begin
          flush = push_ok;
          if (push_ok) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      s1_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      done_q   <= done_d;
      s1_vld_q <= s1_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q   <= s1_idx_d;
    item_idx_q <= item_idx_d;
    goal_q     <= goal_d;
    gdir_q     <= gdir_d;
  end

`ifndef ASSERT_OFF
  // reads and write-backs never touch the same motor in one cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("state memory read and write hit the same entry");

  // no held result is left over from a tick once the sequencer is idle
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_vld)
    else $error("held result left over in idle");

  // set goal write-back is followed by idle in the next cycle
  a_set_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SET) |=> (state_q == ST_IDLE))
    else $error("set goal did not return to idle");

  // results only come out of live sweep data
  a_push_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> ((state_q == ST_SWEEP) && s1_vld_q && wr_en))
    else $error("result pushed without a write-back");
`endif

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb - testbench for motor_pwm_ramp_with_reversal
// Drives set-goal and tick requests over the request channel, predicts every
// ramp step of all four motors and checks each result transfer in order.
// Directed cases first, then a receiver hold-off, then random phases over
// several register settings.
// ----------------------------------------------------------------------------
module tb;
  import mrr_pkg::*;

  localparam int MOTORS       = 4;
  localparam int HOLD_CYCLES  = 300;     // receiver hold-off for the pressure test
  localparam int SETTLE_WAIT  = 20;      // margin for a silent tick sweep or set-goal write-back to finish
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    logic              kind;
    logic [MIDX_W-1:0] motor;
    logic [DUTY_W-1:0] duty;
    logic              dir;
  } ramp_req_t;

  typedef struct {
    logic [MIDX_W-1:0] motor;
    logic [DUTY_W-1:0] duty;
    logic              dir;
    logic              settled;
    logic              last;
  } motor_step_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CIDX_W-1:0]   cfg_idx_i;
  logic [CFG_W-1:0]    cfg_data_i;

  mrr_req_if req_ch ();
  mrr_res_if res_ch ();

  motor_pwm_ramp_with_reversal #(
    .MOTOR_COUNT (MOTORS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_ch),
    .res_o      (res_ch)
  );

  // Predictor copy of the registers and the per-motor state
  logic [DUTY_W-1:0] cfg_step;
  logic [PER_W-1:0]  cfg_period;
  logic [DUTY_W-1:0] cfg_top;

  logic [DUTY_W-1:0] m_duty     [MOTORS];
  logic [DUTY_W-1:0] m_goal     [MOTORS];
  logic              m_dir      [MOTORS];
  logic              m_dir_tgt  [MOTORS];
  logic [PER_W-1:0]  m_timer    [MOTORS];
  logic              m_armed    [MOTORS];

  // Ramp steps predicted but not yet seen on the result channel, oldest first
  motor_step_t due_steps[$];

  int   mismatches = 0;
  int   cycle_cnt  = 0;
  logic src_gaps   = 1'b0;   // sender inserts random gaps
  logic sink_gaps  = 1'b0;   // receiver drops ready at random
  logic hold_on    = 1'b0;   // long receiver hold-off in progress
  event hold_ev;

  // Clock: period 10
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit - a hang anywhere ends up here
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor: applies one accepted request to the model state and queues the
  // ramp steps it causes. A set goal clamps the goal to pwm_top and (re)arms
  // the motor's timer; a tick counts every armed timer down and steps each
  // motor whose timer expires, in ascending motor order. The last step of a
  // tick carries the last-of-tick flag.
  // --------------------------------------------------------------------------
  function automatic void ramp_predict(input ramp_req_t r);
    motor_step_t fired[$];
    motor_step_t st;
    int          d, g, s, left;
    logic        done;
    if (r.kind == REQ_SET) begin
      m_goal[r.motor]    = (r.duty > cfg_top) ? cfg_top : r.duty;
      m_dir_tgt[r.motor] = r.dir;
      m_timer[r.motor]   = cfg_period;
      m_armed[r.motor]   = 1'b1;
      return;
    end
    s = cfg_step;
    for (int m = 0; m < MOTORS; m++) begin
      if (!m_armed[m]) continue;
      if (m_timer[m] > 1) begin
        m_timer[m] = m_timer[m] - 1'b1;
        continue;
      end
      d = m_duty[m];
      g = m_goal[m];
      if (m_dir[m] == m_dir_tgt[m]) begin
        // same direction: step toward the goal, snap when closer than a step
        if (g > d) d = (g - d >= s) ? d + s : g;
        else if (g < d) d = (d - g >= s) ? d - s : g;
      end else if (d > s) begin
        // reversing: spin down first
        d = d - s;
      end else begin
        // reaches zero: flip and spend what is left of the step upward
        left     = s - d;
        m_dir[m] = m_dir_tgt[m];
        d        = (left >= g) ? g : left;
      end
      m_duty[m] = d[DUTY_W-1:0];
      done      = (m_duty[m] == g) && (m_dir[m] == m_dir_tgt[m]);
      if (done) begin
        m_armed[m] = 1'b0;
        m_timer[m] = '0;
      end else begin
        m_timer[m] = cfg_period;
      end
      st.motor   = m[MIDX_W-1:0];
      st.duty    = m_duty[m];
      st.dir     = m_dir[m];
      st.settled = done;
      st.last    = 1'b0;
      fired.push_back(st);
    end
    if (fired.size() > 0) fired[fired.size()-1].last = 1'b1;
    foreach (fired[i]) due_steps.push_back(fired[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: every transfer on the result channel is matched against
  // the oldest predicted step, field by field.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_res
    motor_step_t exp_s;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (due_steps.size() == 0) begin
        if (mismatches < 10)
          $display("[%0t] unexpected result: motor %0d duty %0d dir %0b ",
                   $realtime, res_ch.out_motor, res_ch.duty_value,
                   res_ch.drive_direction,
                   "settled %0b last %0b", res_ch.settled, res_ch.last_of_tick);
        mismatches++;
      end else begin
        exp_s = due_steps.pop_front();
        if (res_ch.out_motor !== exp_s.motor || res_ch.duty_value !== exp_s.duty ||
            res_ch.drive_direction !== exp_s.dir || res_ch.settled !== exp_s.settled ||
            res_ch.last_of_tick !== exp_s.last) begin
          if (mismatches < 10)
            $display("[%0t] mismatch: exp motor %0d duty %0d dir %0b settled %0b last %0b",
                     $realtime, exp_s.motor, exp_s.duty, exp_s.dir, exp_s.settled,
                     exp_s.last,
                     ", got motor %0d duty %0d dir %0b settled %0b last %0b",
                     res_ch.out_motor, res_ch.duty_value, res_ch.drive_direction,
                     res_ch.settled, res_ch.last_of_tick);
          mismatches++;
        end
      end
    end
  end

  // Receiver: ready changes on the falling edge only
  always @(negedge clk_i) begin
    if (hold_on) begin
      res_ch.ready <= 1'b0;
    end else if (sink_gaps) begin
      res_ch.ready <= ($urandom_range(99) >= 24);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Long hold-off, counted on rising edges so it never races the ready driver
  always begin
    @(hold_ev);
    @(posedge clk_i);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_on = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Sender: offers one request from the next falling edge, with an optional
  // gap first, and returns on the rising edge of its transfer. Valid is left
  // high so back-to-back requests need no extra assignment.
  // --------------------------------------------------------------------------
  task automatic send_req(input ramp_req_t r);
    @(negedge clk_i);
    if (src_gaps && $urandom_range(99) < 24) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk_i);
    end
    req_ch.valid          <= 1'b1;
    req_ch.req_type       <= r.kind;
    req_ch.motor_index    <= r.motor;
    req_ch.goal_duty      <= r.duty;
    req_ch.goal_direction <= r.dir;
    do @(posedge clk_i); while (!req_ch.ready);
    ramp_predict(r);
  endtask

  task automatic send_set(input int motor, input int duty, input logic dir);
    ramp_req_t r;
    r.kind  = REQ_SET;
    r.motor = motor[MIDX_W-1:0];
    r.duty  = duty[DUTY_W-1:0];
    r.dir   = dir;
    send_req(r);
  endtask

  // motor, duty and direction are don't-care on a tick, so they carry noise
  task automatic send_tick();
    ramp_req_t r;
    r.kind  = REQ_TICK;
    r.motor = MIDX_W'($urandom_range(MOTORS - 1));
    r.duty  = DUTY_W'($urandom_range(16'hFFFF));
    r.dir   = 1'($urandom_range(1));
    send_req(r);
  endtask

  // Drops valid, waits for every predicted step, then lets a silent sweep or
  // set-goal write-back finish before anything touches the registers.
  task automatic wait_idle();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (due_steps.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_RAMP_STEP:   cfg_step   = val;
      CFG_RAMP_PERIOD: cfg_period = val[PER_W-1:0];
      CFG_PWM_TOP:     cfg_top    = val;
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Directed cases: plain ramps up, a reversal from duty zero, a reversal that
  // lands exactly on zero, clamping to pwm_top, a restart of a running timer,
  // zero step (incl. the flip at duty zero), zero period, full step and a late
  // lowering of pwm_top that must leave stored goals alone.
  // --------------------------------------------------------------------------
  task automatic test_directed_cases();
    write_reg(CFG_RAMP_STEP,   16'd100);
    write_reg(CFG_RAMP_PERIOD, 16'd1);
    write_reg(CFG_PWM_TOP,     16'hFFFF);
    send_set(0, 250, 1'b0);
    send_set(1, 200, 1'b0);
    send_set(2, 0, 1'b1);          // reversal with duty already at zero
    send_set(3, 16'hFFFF, 1'b0);   // largest goal
    repeat (3) send_tick();
    send_set(1, 300, 1'b1);        // 200 -> 100 -> exactly zero, then flip
    repeat (3) send_tick();
    wait_idle();

    write_reg(CFG_RAMP_STEP,   16'd0);
    write_reg(CFG_RAMP_PERIOD, 16'd2);
    write_reg(CFG_PWM_TOP,     16'd1000);
    send_set(3, 5000, 1'b0);       // clamped to 1000
    send_set(2, 0, 1'b0);          // zero step still flips at duty zero
    send_tick();
    send_set(3, 5000, 1'b0);       // restarts a timer that is mid-count
    repeat (2) send_tick();
    wait_idle();

    write_reg(CFG_RAMP_STEP,   16'hFFFF);
    write_reg(CFG_RAMP_PERIOD, 16'd0);
    write_reg(CFG_PWM_TOP,     16'd1);   // goal 1000 on motor 3 stays as stored
    send_set(0, 0, 1'b1);                // zero period: fires on the next tick
    repeat (2) send_tick();
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Back-pressure: all four motors busy on every tick while the receiver holds
  // off; the sender offers ticks and waits while the block refuses them.
  // --------------------------------------------------------------------------
  task automatic test_output_backpressure();
    write_reg(CFG_RAMP_STEP,   16'd1);
    write_reg(CFG_RAMP_PERIOD, 16'd1);
    write_reg(CFG_PWM_TOP,     16'hFFFF);
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    send_set(0, 60000, 1'b0);
    send_set(1, 60000, 1'b1);
    send_set(2, 30000, 1'b0);
    send_set(3, 45000, 1'b1);
    -> hold_ev;
    repeat (16) send_tick();
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Random phases over a spread of settings, extremes included. About a third
  // of the requests set goals, with duties biased toward zero, full scale,
  // pwm_top and a few steps, so reversals and snaps are common. The third
  // phase runs with no gaps on either side.
  // --------------------------------------------------------------------------
  task automatic test_random_ramp();
    int        ph_step  [7] = '{420, 7, 65535, 1500, 5000, 1, 0};
    int        ph_period[7] = '{2, 1, 1, 3, 255, 0, 1};
    int        ph_top   [7] = '{65535, 300, 65535, 40000, 65535, 1, 2};
    int        ph_items [7] = '{50, 45, 45, 45, 20, 45, 20};
    ramp_req_t r;
    for (int p = 0; p < 7; p++) begin
      write_reg(CFG_RAMP_STEP,   ph_step[p][CFG_W-1:0]);
      write_reg(CFG_RAMP_PERIOD, ph_period[p][CFG_W-1:0]);
      write_reg(CFG_PWM_TOP,     ph_top[p][CFG_W-1:0]);
      src_gaps  = (p != 2);
      sink_gaps = (p != 2);
      for (int i = 0; i < ph_items[p]; i++) begin
        if ($urandom_range(99) < 30) begin
          r.kind  = REQ_SET;
          r.motor = MIDX_W'($urandom_range(MOTORS - 1));
          r.dir   = 1'($urandom_range(1));
          case ($urandom_range(4))
            0:       r.duty = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            1:       r.duty = DUTY_W'($urandom_range(3 * int'(cfg_step)));
            2:       r.duty = DUTY_W'(cfg_top + $urandom_range(2) - 1);
            default: r.duty = DUTY_W'($urandom_range(16'hFFFF));
          endcase
          send_req(r);
        end else begin
          send_tick();
        end
      end
      wait_idle();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = CFG_RAMP_STEP;
    cfg_data_i            = '0;
    req_ch.valid          = 1'b0;
    req_ch.req_type       = REQ_TICK;
    req_ch.motor_index    = '0;
    req_ch.goal_duty      = '0;
    req_ch.goal_direction = 1'b0;
    res_ch.ready          = 1'b0;

    // predictor starts from the reset state
    cfg_step   = RESET_RAMP_STEP;
    cfg_period = RESET_RAMP_PERIOD;
    cfg_top    = RESET_PWM_TOP;
    for (int m = 0; m < MOTORS; m++) begin
      m_duty[m]    = '0;
      m_goal[m]    = '0;
      m_dir[m]     = 1'b0;
      m_dir_tgt[m] = 1'b0;
      m_timer[m]   = '0;
      m_armed[m]   = 1'b0;
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_output_backpressure();
    test_random_ramp();
    wait_idle();

    if (mismatches == 0 && due_steps.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
